### rtl/fct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants of the framed command tokenizer
// Transaction payloads, operation and status codes, control characters and
// keyword character tables.
// ----------------------------------------------------------------------------
package fct_pkg;

  // Frame store geometry; the read address field is exactly STORE_AW bits wide
  localparam int STORE_DEPTH = 2048;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int INDEX_W     = STORE_AW + 1;

  // Token limit and counter width
  localparam int TOKEN_LIMIT = 15;
  localparam int TOK_W       = $clog2(TOKEN_LIMIT + 1);

  // Keyword lengths and the smallest counts accepted per command
  localparam int KW_CMD_LEN     = 5;
  localparam int KW_TRUE_LEN    = 4;
  localparam int MIN_TOKENS     = 3;
  localparam int MIN_TOKENS_ID  = 5;
  localparam int TRUE_TOKEN     = 4;

  // Control characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_RS  = 8'h1e;

  // Operation codes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_HANDLED = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Result kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Command status codes
  localparam logic [2:0] STAT_QUERY   = 3'd0;
  localparam logic [2:0] STAT_IDENT   = 3'd1;
  localparam logic [2:0] STAT_TOO_FEW = 3'd2;
  localparam logic [2:0] STAT_UNKNOWN = 3'd3;
  localparam logic [2:0] STAT_ABORT   = 3'd4;

  // Keyword match flag bits
  localparam int FLAG_QUERY = 0;
  localparam int FLAG_IDENT = 1;
  localparam int FLAG_TRUE  = 2;

  // Parser mode
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_WAIT    = 2'd2
  } mode_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [10:0] read_addr;
  } fct_in_t;

  // Output transaction
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        create_account;
    logic [3:0]  token_count;
    logic [10:0] key_start;
    logic [10:0] key_len;
    logic [10:0] server_start;
    logic [10:0] server_len;
    logic [10:0] id_start;
    logic [10:0] id_len;
    logic [7:0]  read_data;
  } fct_out_t;

  // Frame store write command
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  function automatic logic [7:0] query_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h71;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h79;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ident_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h69;
      3'd1:    c = 8'h64;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h6e;
      3'd4:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] true_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/fct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/fct_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_parser: frame parser and tokenizer
// Tracks the frame mode, splits payload into tokens, matches keywords,
// records token extents, drives frame store writes and forms command results.
// ----------------------------------------------------------------------------
module fct_parser import fct_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire fct_in_t   item_i,
  output store_wr_t      wr_o,
  output logic           res_valid_o,
  output fct_out_t       res_o
);

  mode_e                mode_q, mode_d;
  logic [INDEX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [TOK_W-1:0]     tokens_q, tokens_d;
  logic [INDEX_W-1:0]   tok_start_q, tok_start_d;
  logic [2:0]           flags_q, flags_d;
  logic [10:0]          ext_start_q [3];
  logic [10:0]          ext_start_d [3];
  logic [10:0]          ext_len_q [3];
  logic [10:0]          ext_len_d [3];

  logic [TOK_W-1:0]     cur_tok;
  logic [INDEX_W-1:0]   pos;
  logic                 full;
  logic [2:0]           flags_close;
  logic [10:0]          ext_start_close [3];
  logic [10:0]          ext_len_close [3];
  logic [TOK_W-1:0]     count;
  logic [2:0]           etx_status;
  logic [7:0]           b;
  logic                 is_byte;
  logic                 abort;
  logic                 is_rs;
  logic                 is_etx;

  assign b       = item_i.data_byte;
  assign is_byte = accept_i && (item_i.op == OP_BYTE);
  assign full    = (wr_idx_q == INDEX_W'(STORE_DEPTH));
  assign abort   = full || (b == CH_NUL);
  assign is_rs   = (b == CH_RS);
  assign is_etx  = (b == CH_ETX);
  assign cur_tok = (tokens_q < TOK_W'(TOKEN_LIMIT)) ? tokens_q : TOK_W'(TOKEN_LIMIT - 1);
  assign pos     = wr_idx_q - tok_start_q;

  // Close the current token: length checks and extent capture
  always_comb begin
    flags_close     = flags_q;
    ext_start_close = ext_start_q;
    ext_len_close   = ext_len_q;
    if (cur_tok == '0) begin
      if (pos != INDEX_W'(KW_CMD_LEN)) begin
        flags_close[FLAG_QUERY] = 1'b0;
        flags_close[FLAG_IDENT] = 1'b0;
      end
    end else if (cur_tok == TOK_W'(TRUE_TOKEN)) begin
      if (pos != INDEX_W'(KW_TRUE_LEN)) begin
        flags_close[FLAG_TRUE] = 1'b0;
      end
    end else if (cur_tok < TOK_W'(TRUE_TOKEN)) begin
      ext_start_close[2'(cur_tok - 1'b1)] = tok_start_q[10:0];
      ext_len_close[2'(cur_tok - 1'b1)]   = pos[10:0];
    end
  end

  // Decide the command status at end of frame
  always_comb begin
    count = (tokens_q < TOK_W'(TOKEN_LIMIT)) ? tokens_q + 1'b1 : TOK_W'(TOKEN_LIMIT);
    if (count < TOK_W'(MIN_TOKENS)) begin
      etx_status = STAT_TOO_FEW;
    end else if (flags_close[FLAG_QUERY]) begin
      etx_status = STAT_QUERY;
    end else if (flags_close[FLAG_IDENT]) begin
      etx_status = (count < TOK_W'(MIN_TOKENS_ID)) ? STAT_TOO_FEW : STAT_IDENT;
    end else begin
      etx_status = STAT_UNKNOWN;
    end
  end

  // Mode next state
  always_comb begin
    mode_d = mode_q;
    if (accept_i) begin
      if (item_i.op == OP_HANDLED) begin
        mode_d = MODE_IDLE;
      end else if (item_i.op == OP_BYTE) begin
        unique case (mode_q)
          MODE_IDLE: begin
            if (b == CH_STX) begin
              mode_d = MODE_COLLECT;
            end
          end
          MODE_COLLECT: begin
            if (abort) begin
              mode_d = MODE_IDLE;
            end else if (is_etx) begin
              mode_d = (etx_status == STAT_QUERY || etx_status == STAT_IDENT) ?
                       MODE_WAIT : MODE_IDLE;
            end
          end
          MODE_WAIT: mode_d = MODE_WAIT;
          default:   mode_d = MODE_IDLE;
        endcase
      end
    end
  end

  // Frame datapath, store writes and results
  always_comb begin
    wr_idx_d    = wr_idx_q;
    tokens_d    = tokens_q;
    tok_start_d = tok_start_q;
    flags_d     = flags_q;
    ext_start_d = ext_start_q;
    ext_len_d   = ext_len_q;
    wr_o        = '0;
    wr_o.addr   = wr_idx_q[STORE_AW-1:0];
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && item_i.op == OP_READ) begin
      res_valid_o = 1'b1;
      res_o.kind  = KIND_READ;
    end

    if (is_byte && mode_q == MODE_IDLE && b == CH_STX) begin
      // Start a fresh frame
      wr_idx_d    = '0;
      tokens_d    = '0;
      tok_start_d = '0;
      flags_d     = '1;
      for (int i = 0; i < 3; i++) begin
        ext_start_d[i] = '0;
        ext_len_d[i]   = '0;
      end
    end else if (is_byte && mode_q == MODE_COLLECT) begin
      if (abort) begin
        // Drop the frame; store the NUL when there is room
        wr_o.we      = !full;
        wr_o.data    = CH_NUL;
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_CMD;
        res_o.status = STAT_ABORT;
      end else if (is_rs) begin
        wr_o.we  = 1'b1;
        wr_idx_d = wr_idx_q + 1'b1;
        if (tokens_q < TOK_W'(TOKEN_LIMIT)) begin
          wr_o.data   = CH_NUL;
          flags_d     = flags_close;
          ext_start_d = ext_start_close;
          ext_len_d   = ext_len_close;
          tokens_d    = tokens_q + 1'b1;
          tok_start_d = wr_idx_q + 1'b1;
        end else begin
          wr_o.data = b;
        end
      end else if (!is_etx) begin
        // Plain payload byte: advance keyword matches
        wr_o.we   = 1'b1;
        wr_o.data = b;
        wr_idx_d  = wr_idx_q + 1'b1;
        if (cur_tok == '0) begin
          if (!(pos < INDEX_W'(KW_CMD_LEN) && b == query_char(pos[2:0]))) begin
            flags_d[FLAG_QUERY] = 1'b0;
          end
          if (!(pos < INDEX_W'(KW_CMD_LEN) && b == ident_char(pos[2:0]))) begin
            flags_d[FLAG_IDENT] = 1'b0;
          end
        end else if (cur_tok == TOK_W'(TRUE_TOKEN)) begin
          if (!(pos < INDEX_W'(KW_TRUE_LEN) && b == true_char(pos[2:0]))) begin
            flags_d[FLAG_TRUE] = 1'b0;
          end
        end
      end else begin
        // End of frame: close the last token and report
        wr_o.we     = 1'b1;
        wr_o.data   = CH_NUL;
        wr_idx_d    = wr_idx_q + 1'b1;
        flags_d     = flags_close;
        ext_start_d = ext_start_close;
        ext_len_d   = ext_len_close;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_CMD;
        res_o.status      = etx_status;
        res_o.token_count = count;
        if (etx_status == STAT_QUERY || etx_status == STAT_IDENT) begin
          res_o.key_start    = ext_start_close[0];
          res_o.key_len      = ext_len_close[0];
          res_o.server_start = ext_start_close[1];
          res_o.server_len   = ext_len_close[1];
        end
        if (etx_status == STAT_IDENT) begin
          res_o.create_account = flags_close[FLAG_TRUE];
          res_o.id_start       = ext_start_close[2];
          res_o.id_len         = ext_len_close[2];
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      wr_idx_q    <= '0;
      tokens_q    <= '0;
      tok_start_q <= '0;
      flags_q     <= '1;
    end else begin
      mode_q      <= mode_d;
      wr_idx_q    <= wr_idx_d;
      tokens_q    <= tokens_d;
      tok_start_q <= tok_start_d;
      flags_q     <= flags_d;
    end
  end

  // Token extents, cleared at each frame start
  always_ff @(posedge clk_i) begin
    ext_start_q <= ext_start_d;
    ext_len_q   <= ext_len_d;
  end

endmodule
`default_nettype wire

### rtl/framed_command_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_command_tokenizer: STX/ETX framed serial command parser
// Stores frame payload in a byte store, tokenizes at RS and reports one
// command result per frame; serves byte reads from the store.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock cycle while the input is not stalled.
// Each received byte costs one write to the frame store and small compare
// updates in the same cycle, so bytes stream back to back. Every result
// passes through a result stage, where a read reply picks up the store's
// registered read data, and then the output register. The input stalls
// only while both stages hold results and the output is stalled. The store
// has no reset; reading an entry that was never written returns an
// unspecified byte.
module framed_command_tokenizer import fct_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire fct_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output fct_out_t      out_data_o
);

  logic       in_accept;
  store_wr_t  store_wr;
  logic       res_valid;
  fct_out_t   res;
  logic [7:0] rd_data;
  logic       rd_en;

  logic       s1_valid_q, s1_valid_d;
  fct_out_t   s1_res_q;
  fct_out_t   s1_out;
  logic       s1_move;
  logic       out_valid_q, out_valid_d;
  fct_out_t   out_q;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rd_en      = in_accept && (in_data_i.op == OP_READ);

  fct_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_data_i),
    .wr_o        (store_wr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fct_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_wr.we),
    .waddr_i (store_wr.addr),
    .wdata_i (store_wr.data),
    .re_i    (rd_en),
    .raddr_i (in_data_i.read_addr[STORE_AW-1:0]),
    .rdata_o (rd_data)
  );

  // Result stage and output register occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = res_valid;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Merge store read data into read replies
  always_comb begin
    s1_out           = s1_res_q;
    s1_out.read_data = (s1_res_q.kind == KIND_READ) ? rd_data : 8'h00;
  end

  // Hold payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_q <= s1_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### rtl/fct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_checker: port-level checks of the framed command tokenizer
// Watches the handshakes and result encodings at the top-level ports.
// ----------------------------------------------------------------------------
module fct_checker import fct_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire fct_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire fct_out_t out_data_o
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // Stall the input only under output backpressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Keep command fields clear in read replies
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_READ |->
      out_data_o.status == STAT_QUERY && out_data_o.token_count == '0 &&
      out_data_o.create_account == 1'b0 && out_data_o.key_len == '0 &&
      out_data_o.id_len == '0)
    else $error("read reply carries command fields");

  // Clear the count, key start, key length and read data of an aborted frame
  a_abort_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_CMD && out_data_o.status == STAT_ABORT |->
      out_data_o.token_count == '0 && out_data_o.key_start == '0 &&
      out_data_o.key_len == '0 && out_data_o.read_data == '0)
    else $error("aborted result carries fields");

  // Give the ident fields only in ident results
  a_ident_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_CMD && out_data_o.status != STAT_IDENT |->
      out_data_o.create_account == 1'b0 && out_data_o.id_start == '0 &&
      out_data_o.id_len == '0)
    else $error("ident fields set outside an ident result");

endmodule

bind framed_command_tokenizer fct_checker u_fct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the framed command tokenizer
// Sends STX/ETX framed commands, aborted and malformed frames, store reads and
// noise through the input channel, predicts each command result and read
// reply with a shadow parser, and compares them field by field at the output.
// ----------------------------------------------------------------------------
module tb_top;
  import fct_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         LAST_FIELD_TOKEN = 3;
  localparam int         ITEM_TARGET      = 450;
  localparam int         HOLD_CYCLES      = 300;
  localparam int         DRAIN_CYCLES     = 20;
  localparam int         TIMEOUT_NS       = 1_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fct_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fct_out_t out_data;

  // Transactions waiting to be sent and results the block still owes
  fct_in_t     send_q[$];
  fct_out_t    owed_results[$];
  int unsigned total_items;
  int unsigned items_taken = 0;
  int unsigned useful_items = 0;
  int unsigned burst_at = 32'hffff_ffff;
  int unsigned mismatches = 0;

  // Shadow parser state
  mode_e              sh_mode;
  logic [INDEX_W-1:0] sh_wr_idx;
  logic [INDEX_W-1:0] sh_tok_start;
  int unsigned        sh_tokens;
  logic [10:0]        sh_extent [6];
  logic [2:0]         sh_flags;
  logic [7:0]         sh_mem [STORE_DEPTH];
  int unsigned        store_fill;  // entries below this index have been written

  framed_command_tokenizer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow parser
  // --------------------------------------------------------------------------
  function automatic void shadow_clear_frame();
    sh_wr_idx    = '0;
    sh_tok_start = '0;
    sh_tokens    = 0;
    foreach (sh_extent[i]) sh_extent[i] = '0;
    sh_flags = 3'b111;
  endfunction

  function automatic void shadow_reset();
    sh_mode    = MODE_IDLE;
    store_fill = 0;
    shadow_clear_frame();
  endfunction

  // Token being filled; tokens past the limit extend the last one
  function automatic int unsigned open_token();
    return (sh_tokens < TOKEN_LIMIT) ? sh_tokens : TOKEN_LIMIT - 1;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    sh_mem[sh_wr_idx[STORE_AW-1:0]] = b;
    if (sh_wr_idx >= store_fill) store_fill = sh_wr_idx + 1;
  endfunction

  function automatic void match_keyword(int flag, string kw, logic [INDEX_W-1:0] pos,
                                        logic [7:0] b);
    if (pos >= kw.len() || b != kw[pos]) sh_flags[flag] = 1'b0;
  endfunction

  // Close the open token, which ends at the write index
  function automatic void close_token();
    int unsigned        t;
    logic [INDEX_W-1:0] len;
    t   = open_token();
    len = sh_wr_idx - sh_tok_start;
    if (t == 0) begin
      if (len != KW_CMD_LEN) begin
        sh_flags[FLAG_QUERY] = 1'b0;
        sh_flags[FLAG_IDENT] = 1'b0;
      end
    end else if (t == TRUE_TOKEN) begin
      if (len != KW_TRUE_LEN) sh_flags[FLAG_TRUE] = 1'b0;
    end else if (t <= LAST_FIELD_TOKEN) begin
      sh_extent[(t - 1) * 2]     = sh_tok_start[10:0];
      sh_extent[(t - 1) * 2 + 1] = len[10:0];
    end
  endfunction

  // Advance the shadow parser by one transaction; return 1 with the result
  function automatic bit tokenize_step(input fct_in_t it, output fct_out_t res);
    logic [INDEX_W-1:0] pos;
    logic [4:0]         cnt;
    res = '0;
    case (it.op)
      OP_HANDLED: begin
        sh_mode = MODE_IDLE;
        return 1'b0;
      end
      OP_READ: begin
        res.kind      = KIND_READ;
        res.read_data = sh_mem[it.read_addr];
        return 1'b1;
      end
      OP_BYTE: ;
      default: return 1'b0;
    endcase

    if (sh_mode == MODE_IDLE) begin
      if (it.data_byte == CH_STX) begin
        shadow_clear_frame();
        sh_mode = MODE_COLLECT;
      end
      return 1'b0;
    end
    if (sh_mode != MODE_COLLECT) return 1'b0;

    // Abort on a NUL byte or a full store
    if (sh_wr_idx >= STORE_DEPTH || it.data_byte == CH_NUL) begin
      if (sh_wr_idx < STORE_DEPTH) store_byte(CH_NUL);
      sh_mode    = MODE_IDLE;
      res.status = STAT_ABORT;
      return 1'b1;
    end

    if (it.data_byte == CH_RS) begin
      if (sh_tokens < TOKEN_LIMIT) begin
        close_token();
        store_byte(CH_NUL);
        sh_tokens++;
        sh_tok_start = sh_wr_idx + 1;
      end else begin
        store_byte(CH_RS);
      end
      sh_wr_idx++;
      return 1'b0;
    end

    if (it.data_byte != CH_ETX) begin
      pos = sh_wr_idx - sh_tok_start;
      if (open_token() == 0) begin
        match_keyword(FLAG_QUERY, "query", pos, it.data_byte);
        match_keyword(FLAG_IDENT, "ident", pos, it.data_byte);
      end else if (open_token() == TRUE_TOKEN) begin
        match_keyword(FLAG_TRUE, "true", pos, it.data_byte);
      end
      store_byte(it.data_byte);
      sh_wr_idx++;
      return 1'b0;
    end

    // End of frame: close the last token and classify the command
    store_byte(CH_NUL);
    close_token();
    sh_wr_idx++;
    cnt = sh_tokens + 1;
    if (cnt > TOKEN_LIMIT) cnt = TOKEN_LIMIT;
    if (cnt < MIN_TOKENS)
      res.status = STAT_TOO_FEW;
    else if (sh_flags[FLAG_QUERY])
      res.status = STAT_QUERY;
    else if (sh_flags[FLAG_IDENT])
      res.status = (cnt < MIN_TOKENS_ID) ? STAT_TOO_FEW : STAT_IDENT;
    else
      res.status = STAT_UNKNOWN;
    res.token_count = cnt[3:0];
    if (res.status == STAT_QUERY || res.status == STAT_IDENT) begin
      res.key_start    = sh_extent[0];
      res.key_len      = sh_extent[1];
      res.server_start = sh_extent[2];
      res.server_len   = sh_extent[3];
      sh_mode = MODE_WAIT;
    end else begin
      sh_mode = MODE_IDLE;
    end
    if (res.status == STAT_IDENT) begin
      res.create_account = sh_flags[FLAG_TRUE];
      res.id_start       = sh_extent[4];
      res.id_len         = sh_extent[5];
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders; each queued transaction also steps the shadow parser so
  // that the builders know the mode and which store entries hold data
  // --------------------------------------------------------------------------
  function automatic void queue_item(fct_in_t it);
    fct_out_t scratch;
    if (it.op == OP_HANDLED || it.op == OP_READ ||
        (it.op == OP_BYTE && (sh_mode == MODE_COLLECT || it.data_byte == CH_STX)))
      useful_items++;
    void'(tokenize_step(it, scratch));
    send_q.push_back(it);
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    fct_in_t it;
    it.op        = OP_BYTE;
    it.data_byte = b;
    it.read_addr = $urandom;
    queue_item(it);
  endfunction

  function automatic void queue_ctrl(logic [1:0] op);
    fct_in_t it;
    it.op        = op;
    it.data_byte = $urandom;
    it.read_addr = $urandom;
    queue_item(it);
  endfunction

  function automatic void queue_read(logic [10:0] addr);
    fct_in_t it;
    it.op        = OP_READ;
    it.data_byte = $urandom;
    it.read_addr = addr;
    queue_item(it);
  endfunction

  // Read only entries that have been written at least once
  function automatic void queue_any_read();
    if (store_fill != 0) queue_read($urandom_range(store_fill - 1));
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = $urandom;
    while (b == CH_NUL || b == CH_ETX || b == CH_RS) b = $urandom;
    return b;
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void queue_payload(int n);
    repeat (n) queue_byte(payload_byte());
  endfunction

  // Flip a letter's case, drop the last letter or append one
  function automatic string mangle(string kw);
    string s;
    int    k;
    s = kw;
    case ($urandom_range(2))
      0: begin
        k    = $urandom_range(kw.len() - 1);
        s[k] = s[k] ^ 8'h20;
      end
      1:       s = kw.substr(0, kw.len() - 2);
      default: s = {kw, "s"};
    endcase
    return s;
  endfunction

  // Frame of n_tok tokens; token 4 carries fifth unless it is empty
  function automatic void queue_frame(string head, int n_tok, string fifth);
    queue_byte(CH_STX);
    queue_text(head);
    for (int i = 1; i < n_tok; i++) begin
      queue_byte(CH_RS);
      if (i == TRUE_TOKEN && fifth.len() != 0) queue_text(fifth);
      else queue_payload($urandom_range(6));
    end
    queue_byte(CH_ETX);
  endfunction

  // Read back a little, then release the parser if it waits for handling
  function automatic void settle();
    repeat ($urandom_range(2)) queue_any_read();
    if (sh_mode == MODE_WAIT) begin
      if ($urandom_range(2) == 0) queue_byte($urandom);
      queue_ctrl(OP_HANDLED);
    end
  endfunction

  function automatic void queue_broken_frame();
    case ($urandom_range(3))
      0:       queue_frame(mangle("query"), $urandom_range(6, 3), "");
      1:       queue_frame(mangle("ident"), $urandom_range(7, 5), "true");
      2:       queue_frame("ident", $urandom_range(4, 3), "true");
      default: queue_frame($urandom_range(1) ? "query" : "ident", $urandom_range(2, 1), "");
    endcase
  endfunction

  function automatic void queue_aborted_frame();
    queue_byte(CH_STX);
    if ($urandom_range(1)) queue_text("query");
    repeat ($urandom_range(3)) begin
      queue_byte(CH_RS);
      queue_payload($urandom_range(4));
    end
    queue_payload($urandom_range(3));
    if ($urandom_range(3) == 0) queue_ctrl(OP_HANDLED);
    else queue_byte(CH_NUL);
  endfunction

  function automatic void queue_noise();
    case ($urandom_range(3))
      0:       queue_any_read();
      1:       queue_ctrl(OP_UNUSED);
      2:       queue_byte($urandom);
      default: queue_ctrl(OP_HANDLED);
    endcase
  endfunction

  // Fill the store to the last entry, then send one byte too many
  function automatic void queue_overflow_frame();
    if (sh_mode != MODE_IDLE) queue_ctrl(OP_HANDLED);
    queue_byte(CH_STX);
    repeat (STORE_DEPTH) queue_byte(($urandom_range(15) == 0) ? CH_RS : payload_byte());
    case ($urandom_range(2))
      0:       queue_byte(CH_ETX);
      1:       queue_byte(CH_NUL);
      default: queue_byte(payload_byte());
    endcase
    repeat (6) queue_read($urandom_range(STORE_DEPTH - 1, STORE_DEPTH / 2));
    queue_read(STORE_DEPTH - 1);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(fct_out_t got);
    fct_out_t want;
    if (owed_results.size() == 0) begin
      $error("result with no transaction pending: %h", got);
      mismatches++;
      return;
    end
    want = owed_results.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("status", want.status, got.status);
    compare_field("create_account", want.create_account, got.create_account);
    compare_field("token_count", want.token_count, got.token_count);
    compare_field("key_start", want.key_start, got.key_start);
    compare_field("key_len", want.key_len, got.key_len);
    compare_field("server_start", want.server_start, got.server_start);
    compare_field("server_len", want.server_len, got.server_len);
    compare_field("id_start", want.id_start, got.id_start);
    compare_field("id_len", want.id_len, got.id_len);
    compare_field("read_data", want.read_data, got.read_data);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict each accepted transaction, then offer the next one
  // --------------------------------------------------------------------------
  int unsigned tx_gap = 0;
  bit          tx_eager = 1'b0;
  fct_out_t    produced;
  bit          has_result;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        has_result = tokenize_step(in_data, produced);
        if (has_result) owed_results.push_back(produced);
        items_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (send_q.size() != 0) begin
        in_data  <= send_q.pop_front();
        in_valid <= 1'b1;
        tx_gap   <= tx_eager ? 0 : $urandom_range(5);
        if ($urandom_range(47) == 0) tx_eager <= !tx_eager;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, so that the block fills up and stalls its input
  // --------------------------------------------------------------------------
  logic        long_hold = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_cnt = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      long_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (long_hold) begin
      if (hold_cnt == HOLD_CYCLES - 1) begin
        long_hold <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end else if (!hold_done && items_taken >= burst_at) begin
      long_hold <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result, then draw the next stall
  // --------------------------------------------------------------------------
  int unsigned rx_wait = 0;
  int unsigned rx_next;
  bit          rx_eager = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else begin
      rx_next = rx_wait;
      if (out_valid && !out_stall) begin
        check_result(out_data);
        rx_next = rx_eager ? 0 : $urandom_range(5);
        if ($urandom_range(39) == 0) rx_eager <= !rx_eager;
      end else if (rx_next != 0) begin
        rx_next--;
      end
      rx_wait   <= rx_next;
      out_stall <= long_hold || (rx_next != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int  pick;
    bit  burst_done;
    burst_done = 1'b0;
    shadow_reset();

    // Directed: ignored ops and bytes, a minimal query, abort, empty and
    // unknown frames, reads of a keyword byte and a token separator
    queue_ctrl(OP_UNUSED);
    queue_byte(8'hff);
    queue_byte(CH_STX);
    queue_text("query");
    queue_byte(CH_RS);
    queue_byte(CH_RS);
    queue_byte(CH_ETX);
    queue_read(11'd5);
    queue_read(11'd0);
    queue_ctrl(OP_HANDLED);
    queue_byte(CH_STX);
    queue_byte(CH_NUL);
    queue_byte(CH_STX);
    queue_byte(CH_ETX);
    queue_byte(CH_STX);
    queue_text("i");
    queue_byte(CH_RS);
    queue_byte(CH_RS);
    queue_byte(CH_ETX);
    queue_read(11'd1);

    // Random: mostly well-formed commands, the rest broken frames and noise
    useful_items = 0;
    while (useful_items < ITEM_TARGET) begin
      if (!burst_done && useful_items >= ITEM_TARGET / 2) begin
        burst_at = send_q.size();
        repeat (12) queue_any_read();
        burst_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 28)
        queue_frame("query", $urandom_range(6, 3), "");
      else if (pick < 52)
        queue_frame("ident", $urandom_range(8, 5),
                     ($urandom_range(4) < 3) ? "true" : mangle("true"));
      else if (pick < 66)
        queue_broken_frame();
      else if (pick < 74)
        queue_aborted_frame();
      else if (pick < 79)
        queue_frame($urandom_range(1) ? "query" : "ident", $urandom_range(20, 14), "true");
      else
        queue_noise();
      settle();
    end
    queue_overflow_frame();

    total_items = send_q.size();
    shadow_reset();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken != total_items || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("tb_top failed");
    $finish;
  end

endmodule

### filelist.f
rtl/fct_pkg.sv
rtl/fct_ram.sv
rtl/fct_parser.sv
rtl/framed_command_tokenizer.sv
rtl/fct_checker.sv
verif/tb_top.sv
